// ===== sv/kmln_pkg.sv =====
// shared types and constants for the k-mutex lamport node
package kmln_pkg;
  typedef enum logic [1:0] {
    ACT_RECEIVE = 2'd0,
    ACT_REQ_TICKET = 2'd1,
    ACT_REL_TICKET = 2'd2,
    ACT_REQ_WORKSHOP = 2'd3
  } action_t;

  localparam logic [2:0] KIND_TICKET_REQ = 3'd0;
  localparam logic [2:0] KIND_TICKET_REP = 3'd1;
  localparam logic [2:0] KIND_WS_REQ = 3'd2;
  localparam logic [2:0] KIND_WS_REP = 3'd3;
  localparam logic [2:0] KIND_END = 3'd4;
  localparam logic [2:0] KIND_GRANT = 3'd5;
  localparam logic [2:0] KIND_ENTER = 3'd6;
  localparam logic [2:0] KIND_NONE = 3'd7;

  typedef enum logic [1:0] {
    MODE_RELEASED = 2'd0,
    MODE_HELD = 2'd1,
    MODE_REQUESTED = 2'd2
  } mode_t;

  localparam logic [1:0] REG_NODE_ID = 2'd0;
  localparam logic [1:0] REG_NODE_COUNT = 2'd1;
  localparam logic [1:0] REG_TICKET_CAP = 2'd2;
  localparam logic [1:0] REG_WS_CAP = 2'd3;

  localparam logic [4:0] TALLY_MAX = 5'd31;
endpackage

// ===== sv/kmln_if.sv =====
// valid/ready channel interfaces for commands, results and configuration
interface kmln_in_if #(parameter int STAMP_BITS = 32, parameter int WORKSHOP_BITS = 8);
  logic valid;
  logic ready;
  logic [1:0] action;
  logic [2:0] msg_kind;
  logic [STAMP_BITS-1:0] msg_stamp;
  logic [3:0] msg_sender;
  logic [WORKSHOP_BITS-1:0] msg_workshop;
  logic [STAMP_BITS-1:0] msg_request_id;
  logic [WORKSHOP_BITS-1:0] workshop_choice;
  modport source (output valid, action, msg_kind, msg_stamp, msg_sender, msg_workshop,
                  msg_request_id, workshop_choice, input ready);
  modport sink (input valid, action, msg_kind, msg_stamp, msg_sender, msg_workshop,
                msg_request_id, workshop_choice, output ready);
endinterface

interface kmln_out_if #(parameter int STAMP_BITS = 32, parameter int WORKSHOP_BITS = 8);
  logic valid;
  logic ready;
  logic [2:0] out_kind;
  logic [3:0] out_dest;
  logic out_broadcast;
  logic [STAMP_BITS-1:0] out_stamp;
  logic [WORKSHOP_BITS-1:0] out_workshop;
  logic [STAMP_BITS-1:0] out_request_id;
  logic all_done;
  logic out_last;
  modport source (output valid, out_kind, out_dest, out_broadcast, out_stamp, out_workshop,
                  out_request_id, all_done, out_last, input ready);
  modport sink (input valid, out_kind, out_dest, out_broadcast, out_stamp, out_workshop,
                out_request_id, all_done, out_last, output ready);
endinterface

interface kmln_cfg_if;
  logic valid;
  logic ready;
  logic [1:0] index;
  logic [4:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== sv/k_mutex_lamport_node_unit.sv =====
// k-mutex lamport node: command/message handling with two ram-held wait queues
// One input beat is taken in the IDLE state and decided in the DECIDE state,
// which waits for a free output slot; no new beat is taken until it is back in IDLE.
// A ticket release or workshop entry then walks its wait queue in ram, one
// result beat per entry (each entry is read from ram in a priming step before
// its beat), giving up to MAX_NODES + 1 result beats. Queue entries live in
// two rams (node and request id packed together), one per queue; no clearing
// pass is needed after reset.
module k_mutex_lamport_node_unit #(
  parameter int MAX_NODES = 16,
  parameter int STAMP_BITS = 32,
  parameter int WORKSHOP_BITS = 8
) (
  input  logic clk,
  input  logic rst,
  kmln_in_if.sink   in_ch,
  kmln_out_if.source out_ch,
  kmln_cfg_if.sink  cfg
);
  localparam int QA = $clog2(MAX_NODES);
  localparam int QL = $clog2(MAX_NODES + 1);
  localparam int EW = 4 + STAMP_BITS;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_DECIDE = 5'b00010,
    ST_SINGLE = 5'b00100,
    ST_WALK = 5'b01000,
    ST_TAIL = 5'b10000
  } state_t;

  state_t state;
  logic [3:0] node_id;
  logic [4:0] node_count, ticket_capacity, workshop_capacity;
  logic [STAMP_BITS-1:0] lamport_clock, own_request_stamp;
  kmln_pkg::mode_t ticket_mode, workshop_mode;
  logic [4:0] reply_tally, end_notice_tally;
  logic [WORKSHOP_BITS-1:0] current_workshop;
  logic [QL-1:0] ticket_wait_len, workshop_wait_len;
  logic done_flag;

  // latched input beat
  logic [1:0] act;
  logic [2:0] mkind;
  logic [STAMP_BITS-1:0] mstamp, mrid;
  logic [3:0] msender;
  logic [WORKSHOP_BITS-1:0] mws, mchoice;

  // walk control
  logic walk_ws;
  logic [QL-1:0] walk_idx, walk_len;
  logic walk_prime;

  // output register
  logic ovalid;
  logic [2:0] okind;
  logic [3:0] odest;
  logic obc, olast;
  logic [STAMP_BITS-1:0] ostamp, orid;
  logic [WORKSHOP_BITS-1:0] ows;

  // rams
  logic t_we, w_we;
  logic [QA-1:0] t_waddr, w_waddr, raddr;
  logic [EW-1:0] wentry, t_rdata, w_rdata;

  kmln_ram #(.WIDTH(EW), .DEPTH(MAX_NODES)) u_tq (
    .clk(clk), .we(t_we), .waddr(t_waddr), .wdata(wentry), .raddr(raddr), .rdata(t_rdata));
  kmln_ram #(.WIDTH(EW), .DEPTH(MAX_NODES)) u_wq (
    .clk(clk), .we(w_we), .waddr(w_waddr), .wdata(wentry), .raddr(raddr), .rdata(w_rdata));

  assign wentry = {msender, mrid};
  assign t_waddr = ticket_wait_len[QA-1:0];
  assign w_waddr = workshop_wait_len[QA-1:0];
  assign raddr = walk_idx[QA-1:0];

  assign in_ch.ready = (state == ST_IDLE);
  assign cfg.ready = 1'b1;
  assign out_ch.valid = ovalid;
  assign out_ch.out_kind = okind;
  assign out_ch.out_dest = odest;
  assign out_ch.out_broadcast = obc;
  assign out_ch.out_stamp = ostamp;
  assign out_ch.out_workshop = ows;
  assign out_ch.out_request_id = orid;
  assign out_ch.all_done = done_flag;
  assign out_ch.out_last = olast;

  logic oslot;
  assign oslot = !ovalid || out_ch.ready;

  // decide-stage combinational values
  logic [STAMP_BITS-1:0] clk_recv, clk_inc;
  logic own_earlier, enq_ok_t, enq_ok_w;
  logic [4:0] tally_inc, end_inc;
  logic [5:0] need_t, need_w, need_e;
  logic tk_grant, ws_grant, is_recv, rel_go, enter_go, fire;
  state_t decide_next;
  always_comb begin
    clk_recv = ((mstamp > lamport_clock) ? mstamp : lamport_clock) + 1'b1;
    clk_inc = lamport_clock + 1'b1;
    own_earlier = (own_request_stamp < mstamp) ||
                  (own_request_stamp == mstamp && node_id < msender);
    enq_ok_t = ticket_wait_len < QL'(MAX_NODES);
    enq_ok_w = workshop_wait_len < QL'(MAX_NODES);
    tally_inc = (reply_tally < kmln_pkg::TALLY_MAX) ? reply_tally + 5'd1 : reply_tally;
    end_inc = (end_notice_tally < kmln_pkg::TALLY_MAX) ? end_notice_tally + 5'd1
                                                       : end_notice_tally;
    need_t = {1'b0, node_count} - {1'b0, ticket_capacity};
    need_w = {1'b0, node_count} - {1'b0, workshop_capacity};
    need_e = {1'b0, node_count} - 6'd1;
    tk_grant = $signed({1'b0, tally_inc}) >= $signed(need_t);
    ws_grant = $signed({1'b0, tally_inc}) >= $signed(need_w);
    is_recv = (kmln_pkg::action_t'(act) == kmln_pkg::ACT_RECEIVE);
    rel_go = (kmln_pkg::action_t'(act) == kmln_pkg::ACT_REL_TICKET) &&
             (ticket_mode == kmln_pkg::MODE_HELD);
    enter_go = is_recv && mkind == kmln_pkg::KIND_WS_REP &&
               workshop_mode == kmln_pkg::MODE_REQUESTED &&
               mrid == own_request_stamp && ws_grant;
    if (rel_go) decide_next = (ticket_wait_len == '0) ? ST_TAIL : ST_WALK;
    else if (enter_go && workshop_wait_len != '0) decide_next = ST_WALK;
    else decide_next = ST_IDLE;
    fire = oslot && ((state == ST_DECIDE && !rel_go) || (state == ST_WALK && !walk_prime) ||
                     state == ST_TAIL);
    t_we = (state == ST_DECIDE) && oslot && is_recv && mkind == kmln_pkg::KIND_TICKET_REQ &&
           (ticket_mode == kmln_pkg::MODE_HELD ||
            (ticket_mode == kmln_pkg::MODE_REQUESTED && own_earlier)) && enq_ok_t;
    w_we = (state == ST_DECIDE) && oslot && is_recv && mkind == kmln_pkg::KIND_WS_REQ &&
           mws == current_workshop &&
           (workshop_mode == kmln_pkg::MODE_HELD ||
            (workshop_mode == kmln_pkg::MODE_REQUESTED && own_earlier)) && enq_ok_w;
  end

  task automatic put(input logic [2:0] k, input logic [3:0] d, input logic b,
                     input logic [STAMP_BITS-1:0] s, input logic [WORKSHOP_BITS-1:0] w,
                     input logic [STAMP_BITS-1:0] r, input logic l);
    okind <= k; odest <= d; obc <= b;
    ostamp <= s; ows <= w; orid <= r; olast <= l;
  endtask

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      node_id <= '0; node_count <= 5'd2; ticket_capacity <= 5'd1; workshop_capacity <= 5'd1;
      lamport_clock <= '0; own_request_stamp <= '0;
      ticket_mode <= kmln_pkg::MODE_RELEASED; workshop_mode <= kmln_pkg::MODE_RELEASED;
      reply_tally <= '0; end_notice_tally <= '0; current_workshop <= '0;
      ticket_wait_len <= '0; workshop_wait_len <= '0; done_flag <= 1'b0;
      ovalid <= 1'b0; walk_idx <= '0; walk_len <= '0; walk_ws <= 1'b0; walk_prime <= 1'b0;
    end else begin
      ovalid <= fire || (ovalid && !out_ch.ready);
      if (cfg.valid) begin
        unique case (cfg.index)
          kmln_pkg::REG_NODE_ID:    node_id <= cfg.data[3:0];
          kmln_pkg::REG_NODE_COUNT: node_count <= cfg.data;
          kmln_pkg::REG_TICKET_CAP: ticket_capacity <= cfg.data;
          kmln_pkg::REG_WS_CAP:     workshop_capacity <= cfg.data;
          default: ;
        endcase
      end
      unique case (state)
        ST_IDLE: begin
          if (in_ch.valid) begin
            act <= in_ch.action; mkind <= in_ch.msg_kind; mstamp <= in_ch.msg_stamp;
            msender <= in_ch.msg_sender; mws <= in_ch.msg_workshop;
            mrid <= in_ch.msg_request_id; mchoice <= in_ch.workshop_choice;
            state <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          if (oslot) begin
            state <= decide_next;
            case (kmln_pkg::action_t'(act))
              kmln_pkg::ACT_REQ_TICKET: begin
                if (ticket_mode == kmln_pkg::MODE_RELEASED) begin
                  ticket_mode <= kmln_pkg::MODE_REQUESTED;
                  lamport_clock <= clk_inc; own_request_stamp <= clk_inc; reply_tally <= '0;
                  put(kmln_pkg::KIND_TICKET_REQ, 4'd0, 1'b1, clk_inc, '0, clk_inc, 1'b1);
                end else put(kmln_pkg::KIND_NONE, 4'd0, 1'b0, '0, '0, '0, 1'b1);
              end
              kmln_pkg::ACT_REL_TICKET: begin
                if (ticket_mode == kmln_pkg::MODE_HELD) begin
                  lamport_clock <= clk_inc;
                  ticket_mode <= kmln_pkg::MODE_RELEASED;
                  walk_ws <= 1'b0; walk_idx <= '0; walk_len <= ticket_wait_len;
                  walk_prime <= 1'b1; ticket_wait_len <= '0;
                end else put(kmln_pkg::KIND_NONE, 4'd0, 1'b0, '0, '0, '0, 1'b1);
              end
              kmln_pkg::ACT_REQ_WORKSHOP: begin
                if (ticket_mode == kmln_pkg::MODE_HELD &&
                    workshop_mode == kmln_pkg::MODE_RELEASED) begin
                  workshop_mode <= kmln_pkg::MODE_REQUESTED;
                  lamport_clock <= clk_inc; own_request_stamp <= clk_inc; reply_tally <= '0;
                  current_workshop <= mchoice;
                  put(kmln_pkg::KIND_WS_REQ, 4'd0, 1'b1, clk_inc, mchoice, clk_inc, 1'b1);
                end else put(kmln_pkg::KIND_NONE, 4'd0, 1'b0, '0, '0, '0, 1'b1);
              end
              default: begin
                lamport_clock <= clk_recv;
                case (mkind)
                  kmln_pkg::KIND_TICKET_REQ: begin
                    if (ticket_mode == kmln_pkg::MODE_HELD ||
                        (ticket_mode == kmln_pkg::MODE_REQUESTED && own_earlier)) begin
                      if (enq_ok_t) ticket_wait_len <= ticket_wait_len + 1'b1;
                      put(kmln_pkg::KIND_NONE, 4'd0, 1'b0, '0, '0, '0, 1'b1);
                    end else
                      put(kmln_pkg::KIND_TICKET_REP, msender, 1'b0, clk_recv, '0, mrid, 1'b1);
                  end
                  kmln_pkg::KIND_TICKET_REP: begin
                    if (ticket_mode == kmln_pkg::MODE_REQUESTED && mrid == own_request_stamp) begin
                      if (tk_grant) begin
                        ticket_mode <= kmln_pkg::MODE_HELD; reply_tally <= '0;
                        put(kmln_pkg::KIND_GRANT, 4'd0, 1'b0, clk_recv, '0,
                            own_request_stamp, 1'b1);
                      end else begin
                        reply_tally <= tally_inc;
                        put(kmln_pkg::KIND_NONE, 4'd0, 1'b0, '0, '0, '0, 1'b1);
                      end
                    end else put(kmln_pkg::KIND_NONE, 4'd0, 1'b0, '0, '0, '0, 1'b1);
                  end
                  kmln_pkg::KIND_WS_REQ: begin
                    if (mws == current_workshop &&
                        (workshop_mode == kmln_pkg::MODE_HELD ||
                         (workshop_mode == kmln_pkg::MODE_REQUESTED && own_earlier))) begin
                      if (enq_ok_w) workshop_wait_len <= workshop_wait_len + 1'b1;
                      put(kmln_pkg::KIND_NONE, 4'd0, 1'b0, '0, '0, '0, 1'b1);
                    end else
                      put(kmln_pkg::KIND_WS_REP, msender, 1'b0, clk_recv, mws, mrid, 1'b1);
                  end
                  kmln_pkg::KIND_WS_REP: begin
                    if (workshop_mode == kmln_pkg::MODE_REQUESTED &&
                        mrid == own_request_stamp) begin
                      if (ws_grant) begin
                        reply_tally <= '0;
                        workshop_mode <= kmln_pkg::MODE_RELEASED;
                        put(kmln_pkg::KIND_ENTER, 4'd0, 1'b0, clk_recv, current_workshop,
                            own_request_stamp, workshop_wait_len == '0);
                        walk_ws <= 1'b1; walk_idx <= '0; walk_len <= workshop_wait_len;
                        walk_prime <= 1'b1; workshop_wait_len <= '0;
                      end else begin
                        reply_tally <= tally_inc;
                        put(kmln_pkg::KIND_NONE, 4'd0, 1'b0, '0, '0, '0, 1'b1);
                      end
                    end else put(kmln_pkg::KIND_NONE, 4'd0, 1'b0, '0, '0, '0, 1'b1);
                  end
                  kmln_pkg::KIND_END: begin
                    end_notice_tally <= end_inc;
                    if ($signed({1'b0, end_inc}) >= $signed(need_e)) done_flag <= 1'b1;
                    put(kmln_pkg::KIND_NONE, 4'd0, 1'b0, '0, '0, '0, 1'b1);
                  end
                  default: put(kmln_pkg::KIND_NONE, 4'd0, 1'b0, '0, '0, '0, 1'b1);
                endcase
              end
            endcase
          end
        end
        ST_WALK: begin
          if (walk_prime) begin
            walk_prime <= 1'b0;
          end else if (oslot) begin
            if (walk_ws)
              put(kmln_pkg::KIND_WS_REP, w_rdata[EW-1:STAMP_BITS], 1'b0, lamport_clock,
                  current_workshop, w_rdata[STAMP_BITS-1:0], walk_idx + 1'b1 == walk_len);
            else
              put(kmln_pkg::KIND_TICKET_REP, t_rdata[EW-1:STAMP_BITS], 1'b0, lamport_clock,
                  '0, t_rdata[STAMP_BITS-1:0], 1'b0);
            walk_idx <= walk_idx + 1'b1;
            walk_prime <= 1'b1;
            if (walk_idx + 1'b1 == walk_len) state <= walk_ws ? ST_IDLE : ST_TAIL;
          end
        end
        ST_TAIL: begin
          if (oslot) begin
            put(kmln_pkg::KIND_END, 4'd0, 1'b1, lamport_clock, '0, '0, 1'b1);
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end
endmodule

// ===== sv/kmln_ram.sv =====
// generic simple dual-port ram (one write port, one read port) with registered read
module kmln_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== tb/sv/k_mutex_lamport_node_unit_tb.sv =====
// testbench for the k-mutex lamport node: directed and random protocol traffic, scoreboarded
`timescale 1ns / 1ps
module k_mutex_lamport_node_unit_tb;

  typedef struct packed {
    logic [2:0] kind;
    logic [3:0] dest;
    logic bcast;
    logic [31:0] stamp;
    logic [7:0] ws;
    logic [31:0] rid;
    logic done;
    logic last;
  } msg_out_t;

  logic clk;
  logic rst;
  kmln_in_if in_ch();
  kmln_out_if out_ch();
  kmln_cfg_if cfg();

  k_mutex_lamport_node_unit u_dut (.clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .cfg(cfg));

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic [3:0] my_id;
  logic [4:0] n_nodes, tk_cap, ws_cap;
  logic [31:0] lclock, own_stamp;
  kmln_pkg::mode_t tk_mode, ws_mode;
  logic [4:0] tally, end_tally;
  logic [7:0] cur_ws;
  logic done_f;
  logic [3:0] tq_node[16];
  logic [31:0] tq_stamp[16];
  int tq_len;
  logic [3:0] wq_node[16];
  logic [31:0] wq_stamp[16];
  int wq_len;

  msg_out_t pending_msgs[$];
  msg_out_t step_out[$];
  int errors = 0;
  int idle_cycles = 0;
  int items_sent = 0;
  bit hold_off = 0;
  bit long_stall = 0;

  function automatic bit own_first(logic [31:0] s, logic [3:0] snd);
    return own_stamp < s || (own_stamp == s && my_id < snd);
  endfunction

  function automatic bit enough(logic [4:0] t, logic [4:0] cap);
    return $signed({1'b0, t}) >= $signed({1'b0, n_nodes}) - $signed({1'b0, cap});
  endfunction

  function automatic void push_msg(logic [2:0] k, logic [3:0] d, logic b, logic [7:0] w,
                                   logic [31:0] r);
    msg_out_t m;
    m = '{kind: k, dest: d, bcast: b, stamp: lclock, ws: w, rid: r, done: 0, last: 0};
    step_out.push_back(m);
  endfunction

  function automatic void predict(kmln_pkg::action_t a, logic [2:0] k, logic [31:0] ms,
                                  logic [3:0] snd, logic [7:0] mw, logic [31:0] r,
                                  logic [7:0] ch);
    msg_out_t m;
    step_out.delete();
    case (a)
      kmln_pkg::ACT_REQ_TICKET: if (tk_mode == kmln_pkg::MODE_RELEASED) begin
        tk_mode = kmln_pkg::MODE_REQUESTED;
        lclock++;
        own_stamp = lclock;
        tally = 0;
        push_msg(kmln_pkg::KIND_TICKET_REQ, 0, 1, 0, own_stamp);
      end
      kmln_pkg::ACT_REL_TICKET: if (tk_mode == kmln_pkg::MODE_HELD) begin
        lclock++;
        tk_mode = kmln_pkg::MODE_RELEASED;
        for (int i = 0; i < tq_len; i++)
          push_msg(kmln_pkg::KIND_TICKET_REP, tq_node[i], 0, 0, tq_stamp[i]);
        tq_len = 0;
        push_msg(kmln_pkg::KIND_END, 0, 1, 0, 0);
      end
      kmln_pkg::ACT_REQ_WORKSHOP:
        if (tk_mode == kmln_pkg::MODE_HELD && ws_mode == kmln_pkg::MODE_RELEASED) begin
          ws_mode = kmln_pkg::MODE_REQUESTED;
          lclock++;
          own_stamp = lclock;
          tally = 0;
          cur_ws = ch;
          push_msg(kmln_pkg::KIND_WS_REQ, 0, 1, cur_ws, own_stamp);
        end
      default: begin
        lclock = ((ms > lclock) ? ms : lclock) + 1;
        case (k)
          kmln_pkg::KIND_TICKET_REQ:
            if (tk_mode == kmln_pkg::MODE_HELD ||
                (tk_mode == kmln_pkg::MODE_REQUESTED && own_first(ms, snd))) begin
              if (tq_len < 16) begin
                tq_node[tq_len] = snd;
                tq_stamp[tq_len] = r;
                tq_len++;
              end
            end else push_msg(kmln_pkg::KIND_TICKET_REP, snd, 0, 0, r);
          kmln_pkg::KIND_TICKET_REP:
            if (tk_mode == kmln_pkg::MODE_REQUESTED && r == own_stamp) begin
              if (tally < kmln_pkg::TALLY_MAX) tally++;
              if (enough(tally, tk_cap)) begin
                tk_mode = kmln_pkg::MODE_HELD;
                tally = 0;
                push_msg(kmln_pkg::KIND_GRANT, 0, 0, 0, own_stamp);
              end
            end
          kmln_pkg::KIND_WS_REQ:
            if (mw == cur_ws && (ws_mode == kmln_pkg::MODE_HELD ||
                (ws_mode == kmln_pkg::MODE_REQUESTED && own_first(ms, snd)))) begin
              if (wq_len < 16) begin
                wq_node[wq_len] = snd;
                wq_stamp[wq_len] = r;
                wq_len++;
              end
            end else push_msg(kmln_pkg::KIND_WS_REP, snd, 0, mw, r);
          kmln_pkg::KIND_WS_REP:
            if (ws_mode == kmln_pkg::MODE_REQUESTED && r == own_stamp) begin
              if (tally < kmln_pkg::TALLY_MAX) tally++;
              if (enough(tally, ws_cap)) begin
                tally = 0;
                push_msg(kmln_pkg::KIND_ENTER, 0, 0, cur_ws, own_stamp);
                for (int i = 0; i < wq_len; i++)
                  push_msg(kmln_pkg::KIND_WS_REP, wq_node[i], 0, cur_ws, wq_stamp[i]);
                wq_len = 0;
                ws_mode = kmln_pkg::MODE_RELEASED;
              end
            end
          kmln_pkg::KIND_END: begin
            if (end_tally < kmln_pkg::TALLY_MAX) end_tally++;
            if ($signed({1'b0, end_tally}) >= $signed({1'b0, n_nodes}) - 1) done_f = 1;
          end
          default: ;
        endcase
      end
    endcase
    if (step_out.size() == 0) begin
      m = '0;
      m.kind = kmln_pkg::KIND_NONE;
      step_out.push_back(m);
    end
    foreach (step_out[i]) begin
      m = step_out[i];
      m.done = done_f;
      m.last = (i == step_out.size() - 1);
      pending_msgs.push_back(m);
    end
  endfunction

  task automatic send_item(kmln_pkg::action_t a, logic [2:0] k = 0, logic [31:0] ms = 0,
                           logic [3:0] snd = 0, logic [7:0] mw = 0, logic [31:0] r = 0,
                           logic [7:0] ch = 0);
    in_ch.valid <= 1'b1;
    in_ch.action <= a;
    in_ch.msg_kind <= k;
    in_ch.msg_stamp <= ms;
    in_ch.msg_sender <= snd;
    in_ch.msg_workshop <= mw;
    in_ch.msg_request_id <= r;
    in_ch.workshop_choice <= ch;
    do @(posedge clk); while (!in_ch.ready);
    predict(a, k, ms, snd, mw, r, ch);
    items_sent++;
  endtask

  task automatic send_paced(kmln_pkg::action_t a, logic [2:0] k = 0, logic [31:0] ms = 0,
                            logic [3:0] snd = 0, logic [7:0] mw = 0, logic [31:0] r = 0,
                            logic [7:0] ch = 0);
    send_item(a, k, ms, snd, mw, r, ch);
    if ($urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_msgs.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [4:0] v);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= v;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
    case (idx)
      kmln_pkg::REG_NODE_ID: my_id = v[3:0];
      kmln_pkg::REG_NODE_COUNT: n_nodes = v;
      kmln_pkg::REG_TICKET_CAP: tk_cap = v;
      default: ws_cap = v;
    endcase
  endtask

  task automatic set_config(logic [3:0] id, logic [4:0] nc, logic [4:0] tc, logic [4:0] wc);
    write_reg(kmln_pkg::REG_NODE_ID, {1'b0, id});
    write_reg(kmln_pkg::REG_NODE_COUNT, nc);
    write_reg(kmln_pkg::REG_TICKET_CAP, tc);
    write_reg(kmln_pkg::REG_WS_CAP, wc);
  endtask

  // acquire the ticket with enough replies
  task automatic grab_ticket();
    logic [31:0] s;
    send_paced(kmln_pkg::ACT_REQ_TICKET);
    s = own_stamp;
    while (tk_mode == kmln_pkg::MODE_REQUESTED)
      send_paced(kmln_pkg::ACT_RECEIVE, kmln_pkg::KIND_TICKET_REP,
                 $urandom_range(0, 50) + lclock, 4'($urandom), 0, s);
  endtask

  task automatic test_directed();
    set_config(4'd3, 5'd4, 5'd2, 5'd1);
    send_item(kmln_pkg::ACT_REL_TICKET);
    send_item(kmln_pkg::ACT_REQ_WORKSHOP, 0, 0, 0, 0, 0, 8'hff);
    send_item(kmln_pkg::ACT_RECEIVE, kmln_pkg::KIND_TICKET_REP, 32'd5, 4'd1, 0, 32'd99);
    send_item(kmln_pkg::ACT_RECEIVE, 3'd5, 32'hffff_ffff, 4'hf, 8'hff, 32'hffff_ffff);
    send_item(kmln_pkg::ACT_RECEIVE, 3'd7, 32'd0, 4'd0);
    send_item(kmln_pkg::ACT_RECEIVE, kmln_pkg::KIND_TICKET_REQ, 32'd10, 4'd2, 0, 32'd10);
    send_item(kmln_pkg::ACT_REQ_TICKET);
    send_item(kmln_pkg::ACT_REQ_TICKET);
    send_item(kmln_pkg::ACT_RECEIVE, kmln_pkg::KIND_TICKET_REQ, own_stamp, 4'd2, 0, 32'd7);
    send_item(kmln_pkg::ACT_RECEIVE, kmln_pkg::KIND_TICKET_REQ, own_stamp, 4'd5, 0, 32'd8);
    send_item(kmln_pkg::ACT_RECEIVE, kmln_pkg::KIND_TICKET_REP, 0, 4'd1, 0, own_stamp + 1);
    send_item(kmln_pkg::ACT_RECEIVE, kmln_pkg::KIND_TICKET_REP, 0, 4'd1, 0, own_stamp);
    send_item(kmln_pkg::ACT_RECEIVE, kmln_pkg::KIND_TICKET_REP, 0, 4'd2, 0, own_stamp);
    send_item(kmln_pkg::ACT_REQ_WORKSHOP, 0, 0, 0, 0, 0, 8'd7);
    send_item(kmln_pkg::ACT_RECEIVE, kmln_pkg::KIND_WS_REQ, 0, 4'd1, 8'd9, 32'd1);
    send_item(kmln_pkg::ACT_RECEIVE, kmln_pkg::KIND_WS_REQ, own_stamp + 5, 4'd6, 8'd7, 32'd2);
    for (int i = 0; i < 3; i++)
      send_item(kmln_pkg::ACT_RECEIVE, kmln_pkg::KIND_WS_REP, 0, 4'(i), 8'd7, own_stamp);
    for (int i = 0; i < 3; i++) send_item(kmln_pkg::ACT_RECEIVE, kmln_pkg::KIND_END, 0, 4'(i));
    send_item(kmln_pkg::ACT_REL_TICKET);
    drain();
  endtask

  // fill both queues past their depth then flush them
  task automatic test_full_queues();
    set_config(4'd0, 5'd16, 5'd16, 5'd16);
    grab_ticket();
    for (int i = 0; i < 18; i++)
      send_paced(kmln_pkg::ACT_RECEIVE, kmln_pkg::KIND_TICKET_REQ, $urandom, 4'($urandom), 0,
                 $urandom);
    send_paced(kmln_pkg::ACT_REQ_WORKSHOP, 0, 0, 0, 0, 0, 8'd0);
    for (int i = 0; i < 18; i++)
      send_paced(kmln_pkg::ACT_RECEIVE, kmln_pkg::KIND_WS_REQ,
                 own_stamp + 1 + $urandom_range(0, 9), 4'($urandom), 8'd0, $urandom);
    send_paced(kmln_pkg::ACT_RECEIVE, kmln_pkg::KIND_WS_REP, 32'hffff_fff0, 4'd1, 8'd0,
               own_stamp);
    send_paced(kmln_pkg::ACT_RECEIVE, kmln_pkg::KIND_TICKET_REQ, 0, 4'd1, 0, 32'h1234);
    send_paced(kmln_pkg::ACT_REL_TICKET);
    drain();
  endtask

  // receiver holds off while the sender keeps offering
  task automatic test_backpressure();
    set_config(4'd15, 5'd2, 5'd1, 5'd1);
    hold_off = 1;
    for (int i = 0; i < 12; i++)
      send_item(kmln_pkg::ACT_RECEIVE, kmln_pkg::KIND_TICKET_REQ, $urandom, 4'($urandom), 0,
                $urandom);
    hold_off = 0;
    drain();
  endtask

  task automatic test_random(int items);
    int stop;
    logic [31:0] s;
    stop = items_sent + items;
    while (items_sent < stop) begin
      if ($urandom_range(0, 9) < 7) begin
        grab_ticket();
        repeat ($urandom_range(0, 4)) begin
          send_paced(kmln_pkg::ACT_RECEIVE,
                     $urandom_range(0, 1) ? kmln_pkg::KIND_TICKET_REQ : kmln_pkg::KIND_WS_REQ,
                     lclock + $urandom_range(0, 3) - 2, 4'($urandom),
                     8'($urandom_range(0, 3)), $urandom);
        end
        if ($urandom_range(0, 2) != 0) begin
          send_paced(kmln_pkg::ACT_REQ_WORKSHOP, 0, 0, 0, 0, 0, 8'($urandom_range(0, 3)));
          s = own_stamp;
          repeat ($urandom_range(0, 4)) begin
            send_paced(kmln_pkg::ACT_RECEIVE, kmln_pkg::KIND_WS_REQ, s + $urandom_range(0, 2) - 1,
                       4'($urandom), cur_ws, $urandom);
          end
          while (ws_mode == kmln_pkg::MODE_REQUESTED) begin
            send_paced(kmln_pkg::ACT_RECEIVE, kmln_pkg::KIND_WS_REP, $urandom_range(0, 100),
                       4'($urandom), cur_ws, s);
          end
        end
        send_paced(kmln_pkg::ACT_REL_TICKET);
      end else begin
        send_paced(kmln_pkg::action_t'($urandom_range(0, 3)), 3'($urandom_range(0, 7)),
                   $urandom, 4'($urandom), 8'($urandom),
                   $urandom_range(0, 1) ? own_stamp : $urandom, 8'($urandom));
      end
    end
    drain();
  endtask

  initial begin
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.action = kmln_pkg::ACT_RECEIVE;
    in_ch.msg_kind = '0;
    in_ch.msg_stamp = '0;
    in_ch.msg_sender = '0;
    in_ch.msg_workshop = '0;
    in_ch.msg_request_id = '0;
    in_ch.workshop_choice = '0;
    cfg.valid = 1'b0;
    cfg.index = '0;
    cfg.data = '0;
    my_id = 0; n_nodes = 2; tk_cap = 1; ws_cap = 1;
    lclock = 0; own_stamp = 0; tk_mode = kmln_pkg::MODE_RELEASED;
    ws_mode = kmln_pkg::MODE_RELEASED;
    tally = 0; end_tally = 0; cur_ws = 0; done_f = 0; tq_len = 0; wq_len = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_item(kmln_pkg::ACT_RECEIVE, kmln_pkg::KIND_TICKET_REQ, 32'd1, 4'd1, 0, 32'd1);
    drain();
    test_directed();
    test_full_queues();
    test_backpressure();
    set_config(4'd7, 5'd5, 5'd2, 5'd3);
    test_random(120);
    set_config(4'd1, 5'd3, 5'd1, 5'd2);
    test_random(140);
    if (errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  // receiver stall pattern, with one long hold-off
  initial begin
    out_ch.ready = 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_off && !long_stall) begin
        long_stall = 1;
        out_ch.ready <= 1'b0;
        repeat (300) @(posedge clk);
      end
      out_ch.ready <= ($urandom_range(0, 15) < 11) || (($urandom_range(0, 9) == 0));
    end
  end

  always @(posedge clk) begin
    msg_out_t got, want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got = '{kind: out_ch.out_kind, dest: out_ch.out_dest, bcast: out_ch.out_broadcast,
              stamp: out_ch.out_stamp, ws: out_ch.out_workshop, rid: out_ch.out_request_id,
              done: out_ch.all_done, last: out_ch.out_last};
      if (pending_msgs.size() == 0) begin
        $error("result beat with nothing expected: kind %0d", got.kind);
        errors++;
      end else begin
        want = pending_msgs.pop_front();
        if (got.kind != want.kind) begin
          $error("out_kind expected %0d actual %0d", want.kind, got.kind); errors++;
        end
        if (got.dest != want.dest) begin
          $error("out_dest expected %0d actual %0d", want.dest, got.dest); errors++;
        end
        if (got.bcast != want.bcast) begin
          $error("out_broadcast expected %0d actual %0d", want.bcast, got.bcast); errors++;
        end
        if (got.stamp != want.stamp) begin
          $error("out_stamp expected %0h actual %0h", want.stamp, got.stamp); errors++;
        end
        if (got.ws != want.ws) begin
          $error("out_workshop expected %0d actual %0d", want.ws, got.ws); errors++;
        end
        if (got.rid != want.rid) begin
          $error("out_request_id expected %0h actual %0h", want.rid, got.rid); errors++;
        end
        if (got.done != want.done) begin
          $error("all_done expected %0d actual %0d", want.done, got.done); errors++;
        end
        if (got.last != want.last) begin
          $error("out_last expected %0d actual %0d", want.last, got.last); errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg.valid && cfg.ready) || rst)
      idle_cycles <= 0;
    else if (idle_cycles >= 5000) begin
      $display("Verification failed");
      $finish;
    end else
      idle_cycles <= idle_cycles + 1;
  end
endmodule
